[design/drs_pkg.sv]
// Shared constants, command and status types and arithmetic helpers of the decimal sorter.
package drs_pkg;

  // Widths of the key and index fields, and the depth of the stores.
  localparam int IdxW     = 6;
  localparam int MaxItems = 1 << IdxW;
  localparam int CntW     = IdxW + 1;
  localparam int KeyW     = 16;
  localparam int DigW     = 4;
  localparam int Radix    = 10;

  // Reciprocal of ten, exact for every 16-bit dividend.
  localparam logic [KeyW-1:0] RecipTen   = 16'hCCCD;
  localparam int              RecipShift = 19;

  // Work phase that the controller hands to the datapath.
  typedef enum logic [2:0] {
    PH_LOAD,
    PH_HOLD,
    PH_SWEEP,
    PH_COUNT,
    PH_PREFIX,
    PH_SCATTER,
    PH_EMIT
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   start;
    logic   next_pass;
    logic   finish;
  } drs_cmd_t;

  typedef struct packed {
    logic sort_req;
    logic walk_done;
    logic rest_zero;
  } drs_status_t;

  // Quotient of a key divided by ten, by multiplication with the reciprocal.
  function automatic logic [KeyW-1:0] div_ten(input logic [KeyW-1:0] v);
    logic [2*KeyW-1:0] prod;
    prod = {{KeyW{1'b0}}, v} * {{KeyW{1'b0}}, RecipTen};
    return {{(RecipShift-KeyW){1'b0}}, prod[2*KeyW-1:RecipShift]};
  endfunction

  // Lowest decimal digit of a value, given its quotient by ten.
  function automatic logic [DigW-1:0] low_digit(input logic [KeyW-1:0] v,
                                                input logic [KeyW-1:0] q);
    logic [KeyW-1:0] rem;
    rem = v - ((q << 3) + (q << 1));
    return rem[DigW-1:0];
  endfunction

endpackage

[design/drs_ctrl.sv]
// Controller state machine that sequences loading, the digit passes and emission.
module drs_ctrl import drs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  drs_status_t status_i,
  output drs_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_SWEEP,
    S_COUNT,
    S_PREFIX,
    S_SCATTER,
    S_NEXT,
    S_EMIT,
    S_DONE
  } state_e;

  state_e   state_q;
  drs_cmd_t cmd_q;
  logic     done;

  // A walk counts as finished only once its start pulse has gone by.
  assign done  = status_i.walk_done && !cmd_q.start;
  assign cmd_o = cmd_q;

  // State and registered command outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_LOAD;
      cmd_q.phase     <= PH_LOAD;
      cmd_q.start     <= 1'b0;
      cmd_q.next_pass <= 1'b0;
      cmd_q.finish    <= 1'b0;
    end else begin
      cmd_q.start     <= 1'b0;
      cmd_q.next_pass <= 1'b0;
      cmd_q.finish    <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (status_i.sort_req) begin
            state_q     <= S_CHECK;
            cmd_q.phase <= PH_HOLD;
          end
        end
        S_CHECK: begin
          cmd_q.start <= 1'b1;
          if (status_i.rest_zero) begin
            state_q     <= S_EMIT;
            cmd_q.phase <= PH_EMIT;
          end else begin
            state_q     <= S_SWEEP;
            cmd_q.phase <= PH_SWEEP;
          end
        end
        S_SWEEP: begin
          if (done) begin
            state_q     <= S_COUNT;
            cmd_q.phase <= PH_COUNT;
            cmd_q.start <= 1'b1;
          end
        end
        S_COUNT: begin
          if (done) begin
            state_q     <= S_PREFIX;
            cmd_q.phase <= PH_PREFIX;
            cmd_q.start <= 1'b1;
          end
        end
        S_PREFIX: begin
          if (done) begin
            state_q     <= S_SCATTER;
            cmd_q.phase <= PH_SCATTER;
            cmd_q.start <= 1'b1;
          end
        end
        S_SCATTER: begin
          if (done) begin
            state_q         <= S_NEXT;
            cmd_q.phase     <= PH_HOLD;
            cmd_q.next_pass <= 1'b1;
          end
        end
        S_NEXT: begin
          state_q <= S_CHECK;
        end
        S_EMIT: begin
          if (done) begin
            state_q      <= S_DONE;
            cmd_q.phase  <= PH_HOLD;
            cmd_q.finish <= 1'b1;
          end
        end
        S_DONE: begin
          state_q     <= S_LOAD;
          cmd_q.phase <= PH_LOAD;
        end
        default: begin
          state_q     <= S_LOAD;
          cmd_q.phase <= PH_LOAD;
        end
      endcase
    end
  end

endmodule

[design/drs_datapath.sv]
// Datapath of the decimal sorter: stores, digit counters, walk pipelines and output register.
module drs_datapath import drs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  drs_cmd_t        cmd_i,
  output drs_status_t     status_o,
  input  logic            cfg_we_i,
  input  logic            use_given_order_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [KeyW-1:0] key_i,
  input  logic [IdxW-1:0] start_index_i,
  input  logic            last_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdxW-1:0] sorted_index_o,
  output logic            last_result_o
);

  // Stores.
  logic [KeyW-1:0] key_mem  [MaxItems];
  logic [KeyW-1:0] work_mem [MaxItems];
  logic [DigW-1:0] dig_mem  [MaxItems];
  logic [IdxW-1:0] ord_a_mem[MaxItems];
  logic [IdxW-1:0] ord_b_mem[MaxItems];

  logic [KeyW-1:0] key_rd_q, work_rd_q;
  logic [DigW-1:0] dig_rd_q;
  logic [IdxW-1:0] ord_a_rd_q, ord_b_rd_q;

  // Control registers.
  logic            use_given_q;
  logic [CntW-1:0] count_q;
  logic [KeyW-1:0] largest_q;
  logic            src_b_q;
  logic            first_pass_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] acc_q;
  logic [CntW-1:0] cnt_q[Radix];

  // Walk pipeline flags and carried payload.
  logic            s1_v_q;
  logic [IdxW-1:0] s1_addr_q;
  logic            a_v_q;
  logic            b_v_q;
  logic [IdxW-1:0] b_ent_q;
  logic            pend_q, pend_last_q;
  logic            out_v_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_last_q;

  logic            in_acc, room, load_wr;
  logic            ph_sweep, ph_count, ph_prefix, ph_scatter, ph_emit;
  logic [CntW-1:0] walk_len;
  logic            at_end, step, load_out, emit_issue;
  logic            ord_rd_en;
  logic [CntW-1:0] rev_idx;
  logic [IdxW-1:0] ord_rd_addr, ord_rd_sel;
  logic [KeyW-1:0] sw_val, sw_quot;
  logic [DigW-1:0] sw_dig;
  logic            d_ok, sc_wr;
  logic [CntW-1:0] cur_cnt, slot;
  logic            ord_a_we, ord_b_we;
  logic [IdxW-1:0] ord_a_waddr, ord_a_wdata;

  assign ph_sweep   = cmd_i.phase == PH_SWEEP;
  assign ph_count   = cmd_i.phase == PH_COUNT;
  assign ph_prefix  = cmd_i.phase == PH_PREFIX;
  assign ph_scatter = cmd_i.phase == PH_SCATTER;
  assign ph_emit    = cmd_i.phase == PH_EMIT;

  // Input requests are taken only while the block is loading.
  assign in_stall_o = cmd_i.phase != PH_LOAD;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = count_q != CntW'(MaxItems);
  assign load_wr    = in_acc && room;

  // Length of the current walk and the issue conditions.
  always_comb begin
    case (cmd_i.phase)
      PH_SWEEP:  walk_len = CntW'(MaxItems);
      PH_PREFIX: walk_len = CntW'(Radix);
      default:   walk_len = count_q;
    endcase
  end

  assign at_end     = idx_q == walk_len;
  assign step       = !cmd_i.start && !at_end && (ph_sweep || ph_count || ph_prefix || ph_scatter);
  assign load_out   = pend_q && (!out_v_q || !out_stall_i);
  assign emit_issue = ph_emit && !cmd_i.start && !at_end && (!pend_q || load_out);

  // Status back to the controller.
  always_comb begin
    status_o.sort_req  = in_acc && last_item_i;
    status_o.rest_zero = largest_q == '0;
    case (cmd_i.phase)
      PH_SWEEP:   status_o.walk_done = at_end && !s1_v_q;
      PH_COUNT:   status_o.walk_done = at_end && !a_v_q && !b_v_q;
      PH_SCATTER: status_o.walk_done = at_end && !a_v_q && !b_v_q;
      PH_PREFIX:  status_o.walk_done = at_end;
      PH_EMIT:    status_o.walk_done = at_end && !pend_q;
      default:    status_o.walk_done = 1'b0;
    endcase
  end

  // Order store read: backward during the scatter walk, forward otherwise.
  assign rev_idx     = count_q - idx_q - CntW'(1);
  assign ord_rd_en   = (step && (ph_count || ph_scatter)) || emit_issue;
  assign ord_rd_addr = ph_scatter ? rev_idx[IdxW-1:0] : idx_q[IdxW-1:0];
  assign ord_rd_sel  = src_b_q ? ord_b_rd_q : ord_a_rd_q;

  // Digit sweep: split each value into its lowest digit and the rest.
  assign sw_val  = first_pass_q ? key_rd_q : work_rd_q;
  assign sw_quot = div_ten(sw_val);
  assign sw_dig  = low_digit(sw_val, sw_quot);

  // Counter lookup for the digit of the entry at the end of the pipeline.
  assign d_ok    = dig_rd_q < DigW'(Radix);
  assign cur_cnt = d_ok ? cnt_q[dig_rd_q] : '0;
  assign slot    = cur_cnt - CntW'(1);
  assign sc_wr   = ph_scatter && b_v_q && d_ok;

  // Order store writes: loading fills store A, the scatter fills the other store.
  assign ord_a_we    = load_wr || (sc_wr && src_b_q);
  assign ord_b_we    = sc_wr && !src_b_q;
  assign ord_a_waddr = load_wr ? count_q[IdxW-1:0] : slot[IdxW-1:0];
  assign ord_a_wdata = load_wr ? (use_given_q ? start_index_i : count_q[IdxW-1:0]) : b_ent_q;

  // Key store.
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      key_mem[count_q[IdxW-1:0]] <= key_i;
    end
    if (step && ph_sweep) begin
      key_rd_q <= key_mem[idx_q[IdxW-1:0]];
    end
  end

  // Working quotient store.
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      work_mem[s1_addr_q] <= sw_quot;
    end
    if (step && ph_sweep) begin
      work_rd_q <= work_mem[idx_q[IdxW-1:0]];
    end
  end

  // Digit store for the current pass.
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      dig_mem[s1_addr_q] <= sw_dig;
    end
    if (a_v_q) begin
      dig_rd_q <= dig_mem[ord_rd_sel];
    end
  end

  // Order store A.
  always_ff @(posedge clk_i) begin
    if (ord_a_we) begin
      ord_a_mem[ord_a_waddr] <= ord_a_wdata;
    end
    if (ord_rd_en) begin
      ord_a_rd_q <= ord_a_mem[ord_rd_addr];
    end
  end

  // Order store B.
  always_ff @(posedge clk_i) begin
    if (ord_b_we) begin
      ord_b_mem[slot[IdxW-1:0]] <= b_ent_q;
    end
    if (ord_rd_en) begin
      ord_b_rd_q <= ord_b_mem[ord_rd_addr];
    end
  end

  // Set bookkeeping: configuration, fill count, largest key and store roles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_given_q  <= 1'b0;
      count_q      <= '0;
      largest_q    <= '0;
      src_b_q      <= 1'b0;
      first_pass_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        use_given_q <= use_given_order_i;
      end
      if (cmd_i.finish) begin
        count_q      <= '0;
        largest_q    <= '0;
        src_b_q      <= 1'b0;
        first_pass_q <= 1'b1;
      end else if (cmd_i.next_pass) begin
        largest_q    <= div_ten(largest_q);
        src_b_q      <= !src_b_q;
        first_pass_q <= 1'b0;
      end else if (load_wr) begin
        count_q <= count_q + CntW'(1);
        if (key_i > largest_q) begin
          largest_q <= key_i;
        end
      end
    end
  end

  // Walk index and pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      s1_v_q <= 1'b0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      pend_q <= 1'b0;
    end else if (cmd_i.start) begin
      idx_q  <= '0;
      s1_v_q <= 1'b0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (step || emit_issue) begin
        idx_q <= idx_q + CntW'(1);
      end
      s1_v_q <= step && ph_sweep;
      a_v_q  <= step && (ph_count || ph_scatter);
      b_v_q  <= a_v_q;
      if (emit_issue) begin
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
    end
  end

  // Payload carried along the walk pipelines; the final entry has no entries after it.
  always_ff @(posedge clk_i) begin
    s1_addr_q <= idx_q[IdxW-1:0];
    if (a_v_q) begin
      b_ent_q <= ord_rd_sel;
    end
    if (emit_issue) begin
      pend_last_q <= rev_idx == '0;
    end
  end

  // Digit counters: clear, count, prefix sum and scatter decrement.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      for (int i = 0; i < Radix; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.start && ph_count) begin
        for (int i = 0; i < Radix; i++) begin
          cnt_q[i] <= '0;
        end
      end else if (cmd_i.start && ph_prefix) begin
        acc_q <= '0;
      end else if (step && ph_prefix) begin
        cnt_q[idx_q[DigW-1:0]] <= cnt_q[idx_q[DigW-1:0]] + acc_q;
        acc_q                  <= cnt_q[idx_q[DigW-1:0]] + acc_q;
      end else if (ph_count && b_v_q && d_ok) begin
        cnt_q[dig_rd_q] <= cur_cnt + CntW'(1);
      end else if (sc_wr) begin
        cnt_q[dig_rd_q] <= slot;
      end
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q  <= ord_rd_sel;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign sorted_index_o = out_idx_q;
  assign last_result_o  = out_last_q;

endmodule

[design/decimal_radix_index_sorter_top.sv]
// Top level of the decimal radix index sorter: controller, datapath and checks.
//
// Usage: keys arrive on the input channel (in_valid_i / in_stall_o), one request
// per key, each with a starting index and a last-item flag. Up to 64 keys are
// stored; further keys of the same set are dropped. The request marked last
// starts the sort, and the input stalls until the whole permutation is issued.
// The sort runs one pass per decimal digit of the largest key. A pass for n
// keys is a 64-entry digit sweep over the key store, a counting walk and a
// backward scatter walk over the n order entries, and a ten-step prefix sum,
// all limited by one read port per store. Results leave on the output channel
// (out_valid_o / out_stall_i), one index per key with the final one flagged,
// at up to one per cycle from an output register; a stall from the receiver
// holds that register and pauses the read-out. If every key is zero the
// starting order is sent as it is.
// use_given_order_i, written with cfg_we_i while idle, selects the starting
// indices from the requests rather than the arrival position.
// Reset empties the set, clears the counters and the output register.
module decimal_radix_index_sorter_top import drs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            use_given_order_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [KeyW-1:0] key_i,
  input  logic [IdxW-1:0] start_index_i,
  input  logic            last_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdxW-1:0] sorted_index_o,
  output logic            last_result_o
);

  drs_cmd_t    cmd;
  drs_status_t status;

  // Sequencer.
  drs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Stores and arithmetic.
  drs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .use_given_order_i (use_given_order_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .key_i             (key_i),
    .start_index_i     (start_index_i),
    .last_item_i       (last_item_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sorted_index_o    (sorted_index_o),
    .last_result_o     (last_result_o)
  );

  // The last request of a set closes the input for the sort.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_item_i) |=> in_stall_o)
    else $error("input accepted straight after the last request of a set");

  // A further pass is only ordered while digits remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.next_pass |-> !status.rest_zero)
    else $error("pass advanced with no digits left");

  // New results appear only while loading is shut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_stall_o)
    else $error("result presented while the input was open");

  // Controller pulses never coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.next_pass, cmd.finish}))
    else $error("overlapping controller pulses");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the decimal radix index sorter top level.
`timescale 1ns / 1ps

module tb_top import drs_pkg::*; ();

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned RandItems    = 350;
  localparam int unsigned PhaseItems   = 120;
  localparam int unsigned HoldCycles   = 1500;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned DirRows      = 23;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            use_given_order_i;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [KeyW-1:0] key_i;
  logic [IdxW-1:0] start_index_i;
  logic            last_item_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [IdxW-1:0] sorted_index_o;
  logic            last_result_o;

  decimal_radix_index_sorter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .use_given_order_i(use_given_order_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .key_i            (key_i),
    .start_index_i    (start_index_i),
    .last_item_i      (last_item_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sorted_index_o   (sorted_index_o),
    .last_result_o    (last_result_o)
  );

  // One entry of the sorted permutation as it should leave the block.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            last_flag;
  } perm_entry_t;

  // One directed request; the typed index is only used for single-key sets.
  typedef struct {
    bit          given;
    int unsigned key;
    int unsigned start;
    bit          last;
    bit          typed;
    int unsigned typed_idx;
  } dir_row_t;

  dir_row_t dir_rows [DirRows] = '{
    '{0, 0,     0,  1, 1, 0},
    '{0, 65535, 63, 1, 1, 0},
    '{0, 65535, 0,  0, 0, 0},
    '{0, 0,     0,  0, 0, 0},
    '{0, 10,    0,  0, 0, 0},
    '{0, 9,     0,  0, 0, 0},
    '{0, 1,     0,  1, 0, 0},
    '{0, 42,    5,  0, 0, 0},
    '{0, 7,     0,  0, 0, 0},
    '{0, 42,    0,  0, 0, 0},
    '{0, 7,     0,  1, 0, 0},
    '{0, 0,     0,  0, 0, 0},
    '{0, 0,     0,  1, 0, 0},
    '{0, 10000, 0,  0, 0, 0},
    '{0, 9999,  0,  1, 0, 0},
    '{1, 300,   2,  0, 0, 0},
    '{1, 20,    0,  0, 0, 0},
    '{1, 1,     1,  1, 0, 0},
    '{1, 0,     1,  0, 0, 0},
    '{1, 0,     0,  1, 0, 0},
    '{1, 5,     3,  0, 0, 0},
    '{1, 50,    1,  1, 0, 0},
    '{1, 65535, 0,  1, 1, 0}
  };

  int unsigned corner_keys [12] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000,
                                    65534, 65535};

  // Mirror of the block's state, kept by the predictor.
  logic [KeyW-1:0] key_mem [MaxItems];
  logic [IdxW-1:0] order_start [MaxItems];
  int unsigned     fill;
  int unsigned     highwater;
  logic [KeyW-1:0] peak_key;
  bit              given_order;

  perm_entry_t perm_due [$];
  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int unsigned idle_len(input int unsigned pct);
    int unsigned r;
    if ($urandom_range(99, 0) >= pct) return 0;
    r = $urandom_range(99, 0);
    if (r < 85) return $urandom_range(3, 1);
    return $urandom_range(60, 12);
  endfunction

  // Loads one request into the mirrored set and, on the last one, sorts the set
  // digit by digit and queues the permutation that the block should emit.
  task automatic predict_permutation(input logic [KeyW-1:0] k, input logic [IdxW-1:0] s,
                                     input bit last, input bit typed,
                                     input logic [IdxW-1:0] typed_idx);
    int unsigned     tally [Radix];
    logic [IdxW-1:0] src [MaxItems];
    logic [IdxW-1:0] dst [MaxItems];
    int unsigned     scale;
    int unsigned     rest;
    int unsigned     dig;
    // A key arriving on a full set is dropped, but its last flag still counts.
    if (fill < MaxItems) begin
      key_mem[fill]     = k;
      order_start[fill] = given_order ? s : IdxW'(fill);
      fill++;
      if (fill > highwater) highwater = fill;
      if (k > peak_key) peak_key = k;
    end
    if (!last) return;

    src   = order_start;
    scale = 1;
    rest  = peak_key;
    // One stable counting pass per decimal digit of the largest key.
    while (rest != 0) begin
      foreach (tally[d]) tally[d] = 0;
      for (int i = 0; i < fill; i++) begin
        dig = (key_mem[src[i]] / scale) % Radix;
        tally[dig]++;
      end
      for (int d = 1; d < Radix; d++) tally[d] += tally[d-1];
      for (int i = fill; i > 0; i--) begin
        dig = (key_mem[src[i-1]] / scale) % Radix;
        tally[dig]--;
        dst[tally[dig]] = src[i-1];
      end
      src   = dst;
      rest  = rest / Radix;
      scale = scale * Radix;
    end

    if (typed) begin
      perm_due.push_back({typed_idx, 1'b1});
    end else begin
      for (int i = 0; i < fill; i++) perm_due.push_back({src[i], i == fill - 1});
    end
    fill     = 0;
    peak_key = '0;
  endtask

  // Offers one request, holds it until accepted, then idles for a random gap.
  task automatic offer(input logic [KeyW-1:0] k, input logic [IdxW-1:0] s, input bit last,
                       input bit typed, input logic [IdxW-1:0] typed_idx);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    key_i         = k;
    start_index_i = s;
    last_item_i   = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_permutation(k, s, last, typed, typed_idx);
    gap = idle_len(send_idle_pct);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Waits for the block to drain and settle, then writes the order mode.
  task automatic set_order_mode(input bit mode);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (perm_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i          = 1'b1;
    use_given_order_i = mode;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    given_order = mode;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        stall_left  = idle_len(recv_idle_pct);
        out_stall_i = (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Compare every accepted result with the oldest expected entry.
  always @(posedge clk_i) begin : check_results
    perm_entry_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (perm_due.size() == 0) begin
        $error("sorted_index %0d arrived with no result expected", sorted_index_o);
        errors++;
      end else begin
        want = perm_due.pop_front();
        if (sorted_index_o !== want.idx) begin
          $error("sorted_index: expected %0d, got %0d", want.idx, sorted_index_o);
          errors++;
        end
        if (last_result_o !== want.last_flag) begin
          $error("last_result: expected %0d, got %0d", want.last_flag, last_result_o);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("decimal_radix_index_sorter_top: mismatch");
    $finish;
  end

  // Main stimulus: directed table first, then random sets in phases.
  initial begin : stimulus
    int unsigned     set_no;
    int unsigned     stored;
    int unsigned     phase_left;
    int unsigned     size;
    int unsigned     n_store;
    int unsigned     avail;
    int unsigned     kind;
    int unsigned     ceiling;
    int unsigned     r;
    logic [KeyW-1:0] k;
    logic [IdxW-1:0] s;

    cfg_we_i          = 1'b0;
    use_given_order_i = 1'b0;
    in_valid_i        = 1'b0;
    key_i             = '0;
    start_index_i     = '0;
    last_item_i       = 1'b0;
    rst_ni            = 1'b0;
    fill              = 0;
    highwater         = 0;
    peak_key          = '0;
    given_order       = 1'b0;
    errors            = 0;
    send_idle_pct     = 25;
    recv_idle_pct     = 25;
    hold_req          = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes, stable ties, zero sets and earlier-set keys.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].given != given_order) set_order_mode(dir_rows[i].given);
      offer(KeyW'(dir_rows[i].key), IdxW'(dir_rows[i].start), dir_rows[i].last,
            dir_rows[i].typed, IdxW'(dir_rows[i].typed_idx));
    end

    // Random part: the order mode toggles each phase and the idling changes.
    set_no     = 0;
    stored     = 0;
    phase_left = 0;
    while (stored < RandItems) begin
      if (phase_left == 0) begin
        set_order_mode(!given_order);
        send_idle_pct = 20 * $urandom_range(3, 0);
        recv_idle_pct = 20 * $urandom_range(3, 0);
        phase_left    = PhaseItems;
      end

      // Mostly small sets; a few large ones and a few that overflow the store.
      r = $urandom_range(99, 0);
      if (set_no == 0) size = MaxItems + 2;
      else if (r < 55) size = $urandom_range(6, 1);
      else if (r < 85) size = $urandom_range(20, 7);
      else if (r < 95) size = $urandom_range(MaxItems, 21);
      else size = $urandom_range(MaxItems + 4, MaxItems + 1);

      n_store = (size < MaxItems) ? size : MaxItems;
      avail   = (highwater > n_store) ? highwater : n_store;
      kind    = (set_no == 0) ? 4 : $urandom_range(9, 0);
      ceiling = 1;
      repeat ($urandom_range(5, 1)) ceiling = ceiling * Radix;
      ceiling = (ceiling > 65536) ? 65535 : ceiling - 1;

      for (int i = 0; i < size; i++) begin
        case (kind)
          0:       k = '0;
          1, 2:    k = KeyW'($urandom_range(9, 0));
          3, 4, 5: k = KeyW'($urandom_range(65535, 0));
          6, 7:    k = KeyW'($urandom_range(ceiling, 0));
          default: k = KeyW'(corner_keys[$urandom_range(11, 0)]);
        endcase
        // Given starting entries only name keys that have been written.
        s = given_order ? IdxW'($urandom_range(avail - 1, 0)) : IdxW'($urandom_range(63, 0));
        offer(k, s, i == size - 1, 1'b0, '0);
      end

      // After the first full set, the receiver holds off while requests continue.
      if (set_no == 0) hold_req = 1'b1;
      set_no++;
      stored     += n_store;
      phase_left = (phase_left > n_store) ? phase_left - n_store : 0;
    end

    // Drain the remaining results and let the block settle.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (perm_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("decimal_radix_index_sorter_top: match");
    end else begin
      $display("decimal_radix_index_sorter_top: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
design/drs_pkg.sv
design/drs_ctrl.sv
design/drs_datapath.sv
design/decimal_radix_index_sorter_top.sv
test/tb_top.sv
